### design/amgt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command/status types and helper functions for the graph traversal block.
package amgt_pkg;

	localparam int N_VERT = 64;
	localparam int VIDX_W = $clog2(N_VERT);
	localparam int CNT_W  = VIDX_W + 1;
	localparam int WGT_W  = 16;

	localparam logic [WGT_W-1:0] NO_EDGE_WEIGHT = 16'hFFFF;

	localparam logic [1:0] FUNC_CLEAR    = 2'd0;
	localparam logic [1:0] FUNC_INSERT   = 2'd1;
	localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

	// adjacency read address select
	localparam logic [1:0] RD_QUEUE = 2'd0;
	localparam logic [1:0] RD_A     = 2'd1;
	localparam logic [1:0] RD_B     = 2'd2;

	typedef struct packed {
		logic       latch_in;
		logic       clr_adj;
		logic [1:0] adj_rd_sel;
		logic       adj_wr_a;
		logic       adj_wr_b;
		logic       trv_init;
		logic       pop_head;
		logic       read_top;
		logic       bfs_load;
		logic       bfs_emit;
		logic       dfs_emit;
		logic       dfs_pop;
		logic       flush;
		logic       bad_out;
	} amgt_cmd_t;

	typedef struct packed {
		logic [1:0] in_func;
		logic       in_ins_ok;
		logic       in_start_ok;
		logic       dfs;
		logic       head_lt_tail;
		logic       tail_zero;
		logic       bfs_cand_zero;
		logic       dfs_cand_zero;
		logic       out_free;
	} amgt_stat_t;

	// index of the lowest set bit; zero when no bit is set
	function automatic logic [VIDX_W-1:0] lowest_idx(input logic [N_VERT-1:0] x);
		logic [N_VERT-1:0] oh;
		logic [VIDX_W-1:0] idx;
		begin
			oh  = x & (~x + N_VERT'(1));
			idx = '0;
			for (int i = 0; i < N_VERT; i++) begin
				if (oh[i]) idx = idx | VIDX_W'(i);
			end
			return idx;
		end
	endfunction

endpackage

### design/amgt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing clear, insert and traversal work.
module amgt_ctrl import amgt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  amgt_stat_t stat,
	output amgt_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CLEAR    = 4'd1;
	localparam logic [3:0] S_INS_RA   = 4'd2;
	localparam logic [3:0] S_INS_WA   = 4'd3;
	localparam logic [3:0] S_INS_RB   = 4'd4;
	localparam logic [3:0] S_INS_WB   = 4'd5;
	localparam logic [3:0] S_TRV_INIT = 4'd6;
	localparam logic [3:0] S_BAD      = 4'd7;
	localparam logic [3:0] S_BFS_POP  = 4'd8;
	localparam logic [3:0] S_BFS_ROW  = 4'd9;
	localparam logic [3:0] S_BFS_LOAD = 4'd10;
	localparam logic [3:0] S_BFS_EMIT = 4'd11;
	localparam logic [3:0] S_DFS_TOP  = 4'd12;
	localparam logic [3:0] S_DFS_ROW  = 4'd13;
	localparam logic [3:0] S_DFS_EVAL = 4'd14;
	localparam logic [3:0] S_FLUSH    = 4'd15;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.adj_rd_sel = RD_QUEUE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					case (stat.in_func)
						FUNC_CLEAR:    state_d = S_CLEAR;
						FUNC_INSERT:   state_d = stat.in_ins_ok ? S_INS_RA : S_IDLE;
						FUNC_TRAVERSE: state_d = stat.in_start_ok ? S_TRV_INIT : S_BAD;
						default:       state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_adj = 1'b1;
				state_d     = S_IDLE;
			end
			S_INS_RA: begin
				cmd.adj_rd_sel = RD_A;
				state_d        = S_INS_WA;
			end
			S_INS_WA: begin
				cmd.adj_wr_a = 1'b1;
				state_d      = S_INS_RB;
			end
			S_INS_RB: begin
				cmd.adj_rd_sel = RD_B;
				state_d        = S_INS_WB;
			end
			S_INS_WB: begin
				cmd.adj_wr_b = 1'b1;
				state_d      = S_IDLE;
			end
			S_TRV_INIT: begin
				cmd.trv_init = 1'b1;
				state_d      = stat.dfs ? S_DFS_TOP : S_BFS_POP;
			end
			S_BAD: begin
				if (stat.out_free) begin
					cmd.bad_out = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_BFS_POP: begin
				if (stat.head_lt_tail) begin
					cmd.pop_head = 1'b1;
					state_d      = S_BFS_ROW;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_BFS_ROW: state_d = S_BFS_LOAD;
			S_BFS_LOAD: begin
				cmd.bfs_load = 1'b1;
				state_d      = S_BFS_EMIT;
			end
			S_BFS_EMIT: begin
				if (stat.bfs_cand_zero) begin
					state_d = S_BFS_POP;
				end else if (stat.out_free) begin
					cmd.bfs_emit = 1'b1;
				end
			end
			S_DFS_TOP: begin
				if (stat.tail_zero) begin
					state_d = S_FLUSH;
				end else begin
					cmd.read_top = 1'b1;
					state_d      = S_DFS_ROW;
				end
			end
			// keep the top entry on the read port so the row holds through a stall
			S_DFS_ROW: begin
				cmd.read_top = 1'b1;
				state_d      = S_DFS_EVAL;
			end
			S_DFS_EVAL: begin
				cmd.read_top = 1'b1;
				if (stat.dfs_cand_zero) begin
					cmd.dfs_pop = 1'b1;
					state_d     = S_DFS_TOP;
				end else if (stat.out_free) begin
					cmd.dfs_emit = 1'b1;
					state_d      = S_DFS_TOP;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

### design/amgt_datapath.sv
`timescale 1ns / 1ps
// Datapath: adjacency memory, pending queue/stack memory, visited marks and result register.
module amgt_datapath import amgt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic [1:0]        func,
	input  logic [VIDX_W-1:0] edge_from,
	input  logic [VIDX_W-1:0] edge_to,
	input  logic [WGT_W-1:0]  edge_weight,
	input  logic [VIDX_W-1:0] start_vertex,
	input  logic              depth_first,
	input  logic              out_stall,
	input  amgt_cmd_t         cmd,
	output amgt_stat_t        stat,
	output logic              out_valid,
	output logic [VIDX_W-1:0] visited_vertex,
	output logic              last_visit,
	output logic              bad_start
);

	logic [CNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]  n_eff;
	logic [N_VERT-1:0] live;

	logic [VIDX_W-1:0] a_q, b_q, s_q;
	logic              del_q, dfs_q;

	logic [N_VERT-1:0] adj_mem [N_VERT];
	logic [N_VERT-1:0] adj_vld_q;
	logic [N_VERT-1:0] adj_rdata_s1;
	logic              adj_rvld_s1;
	logic [N_VERT-1:0] adj_row;
	logic [VIDX_W-1:0] adj_raddr;
	logic              adj_we;
	logic [VIDX_W-1:0] adj_waddr;
	logic [VIDX_W-1:0] bit_idx;
	logic [N_VERT-1:0] bit_mask;
	logic [N_VERT-1:0] adj_wdata;

	logic [VIDX_W-1:0] q_mem [N_VERT];
	logic [VIDX_W-1:0] q_rdata_s1;
	logic [VIDX_W-1:0] q_raddr;
	logic              q_we;
	logic [VIDX_W-1:0] q_waddr;
	logic [VIDX_W-1:0] q_wdata;
	logic [CNT_W-1:0]  head_q, tail_q, tail_m1;

	logic [N_VERT-1:0] visited_q;
	logic [N_VERT-1:0] cand_q;
	logic [N_VERT-1:0] dfs_cand;
	logic [N_VERT-1:0] emit_cand;
	logic [VIDX_W-1:0] emit_idx;
	logic [N_VERT-1:0] emit_oh;
	logic              emit;
	logic [VIDX_W-1:0] hold_vertex_q;

	logic              out_valid_q, out_last_q, out_bad_q;
	logic [VIDX_W-1:0] out_vertex_q;
	logic              out_load, out_free;

	// effective vertex count saturates at the table size
	assign n_eff = (vcount_q > CNT_W'(N_VERT)) ? CNT_W'(N_VERT) : vcount_q;

	always_comb begin
		for (int i = 0; i < N_VERT; i++) live[i] = (CNT_W'(i) < n_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        vcount_q <= CNT_W'(N_VERT);
		else if (cfg_wr_en) vcount_q <= cfg_wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			a_q   <= edge_from;
			b_q   <= edge_to;
			s_q   <= start_vertex;
			del_q <= (edge_weight == NO_EDGE_WEIGHT);
			dfs_q <= depth_first;
		end
	end

	// adjacency memory; a row whose valid bit is clear reads as no edges
	always_comb begin
		case (cmd.adj_rd_sel)
			RD_A:     adj_raddr = a_q;
			RD_B:     adj_raddr = b_q;
			default:  adj_raddr = q_rdata_s1;
		endcase
	end

	assign adj_row   = adj_rvld_s1 ? adj_rdata_s1 : '0;
	assign adj_we    = cmd.adj_wr_a | cmd.adj_wr_b;
	assign adj_waddr = cmd.adj_wr_a ? a_q : b_q;
	assign bit_idx   = cmd.adj_wr_a ? b_q : a_q;
	assign bit_mask  = N_VERT'(1) << bit_idx;
	assign adj_wdata = del_q ? (adj_row & ~bit_mask) : (adj_row | bit_mask);

	always_ff @(posedge clk) begin
		if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
		adj_rdata_s1 <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q   <= '0;
			adj_rvld_s1 <= 1'b0;
		end else begin
			if (cmd.clr_adj)  adj_vld_q <= '0;
			else if (adj_we)  adj_vld_q[adj_waddr] <= 1'b1;
			adj_rvld_s1 <= adj_vld_q[adj_raddr];
		end
	end

	// candidates and emission
	assign dfs_cand  = adj_row & live & ~visited_q;
	assign emit      = cmd.bfs_emit | cmd.dfs_emit;
	assign emit_cand = cmd.dfs_emit ? dfs_cand : cand_q;
	assign emit_idx  = lowest_idx(emit_cand);
	assign emit_oh   = N_VERT'(1) << emit_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
		end else if (cmd.trv_init) begin
			visited_q <= N_VERT'(1) << s_q;
		end else if (emit) begin
			visited_q <= visited_q | emit_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bfs_load)      cand_q <= adj_row & live & ~visited_q;
		else if (cmd.bfs_emit) cand_q <= cand_q & ~emit_oh;
	end

	// pending queue (breadth-first) or stack (depth-first)
	assign tail_m1 = tail_q - CNT_W'(1);
	assign q_raddr = cmd.read_top ? tail_m1[VIDX_W-1:0] : head_q[VIDX_W-1:0];
	assign q_we    = cmd.trv_init | (emit & ~tail_q[CNT_W-1]);
	assign q_waddr = cmd.trv_init ? '0 : tail_q[VIDX_W-1:0];
	assign q_wdata = cmd.trv_init ? s_q : emit_idx;

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		q_rdata_s1 <= q_mem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.trv_init) begin
			head_q <= '0;
			tail_q <= CNT_W'(1);
		end else begin
			if (cmd.pop_head)                    head_q <= head_q + CNT_W'(1);
			if (emit && !tail_q[CNT_W-1])        tail_q <= tail_q + CNT_W'(1);
			else if (cmd.dfs_pop)                tail_q <= tail_m1;
		end
	end

	// hold the newest vertex back one step so the last one can carry the flag
	always_ff @(posedge clk) begin
		if (cmd.trv_init) hold_vertex_q <= s_q;
		else if (emit)    hold_vertex_q <= emit_idx;
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign out_load = emit | cmd.flush | cmd.bad_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)               out_valid_q <= 1'b0;
		else if (out_load)         out_valid_q <= 1'b1;
		else if (!out_stall)       out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_vertex_q <= cmd.bad_out ? '0 : hold_vertex_q;
			out_last_q   <= cmd.flush | cmd.bad_out;
			out_bad_q    <= cmd.bad_out;
		end
	end

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign last_visit     = out_last_q;
	assign bad_start      = out_bad_q;

	assign stat.in_func       = func;
	assign stat.in_ins_ok     = ({1'b0, edge_from} < n_eff) && ({1'b0, edge_to} < n_eff);
	assign stat.in_start_ok   = ({1'b0, start_vertex} < n_eff);
	assign stat.dfs           = dfs_q;
	assign stat.head_lt_tail  = (head_q < tail_q);
	assign stat.tail_zero     = (tail_q == '0);
	assign stat.bfs_cand_zero = (cand_q == '0);
	assign stat.dfs_cand_zero = (dfs_cand == '0);
	assign stat.out_free      = out_free;

endmodule

### design/adjacency_matrix_graph_traversal.sv
`timescale 1ns / 1ps
// Top level of the adjacency-matrix graph traversal block.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_stall   | func, edge_from, edge_to, edge_weight,
//           |                       | start_vertex, depth_first
//  output   | out_valid / out_stall | visited_vertex, last_visit, bad_start
//  config   | cfg_wr_en             | cfg_wr_data (vertex_count)
//
// One item at a time; in_stall is low only while the controller is idle.
// Insert is a read-modify-write of two rows in the adjacency memory.
// Traverse starts with an init step and ends with a flush; breadth-first pops, reads the row
// and loads candidates per dequeued vertex, depth-first reads the stack top and row per step.
// These steps come from the registered reads of the adjacency and pending memories.
// Reset empties the graph and sets vertex_count to 64; no clearing pass is needed.
// A stalled output only freezes the traversal when the result register is still full.
module adjacency_matrix_graph_traversal import amgt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [VIDX_W-1:0] edge_from,
	input  logic [VIDX_W-1:0] edge_to,
	input  logic [WGT_W-1:0]  edge_weight,
	input  logic [VIDX_W-1:0] start_vertex,
	input  logic              depth_first,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VIDX_W-1:0] visited_vertex,
	output logic              last_visit,
	output logic              bad_start
);

	amgt_cmd_t  cmd;
	amgt_stat_t stat;

	amgt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	amgt_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.func           (func),
		.edge_from      (edge_from),
		.edge_to        (edge_to),
		.edge_weight    (edge_weight),
		.start_vertex   (start_vertex),
		.depth_first    (depth_first),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.visited_vertex (visited_vertex),
		.last_visit     (last_visit),
		.bad_start      (bad_start)
	);

endmodule

### design/amgt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the graph traversal block, bound to the top level.
module amgt_checker import amgt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [1:0]        func,
	input logic              out_valid,
	input logic              out_stall,
	input logic [VIDX_W-1:0] visited_vertex,
	input logic              last_visit,
	input logic              bad_start
);

	// a bad start is a single, final result with vertex zero
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_start |-> last_visit && (visited_vertex == '0))
		else $error("bad start result without last flag or with nonzero vertex");

	// a traversal is still running while a non-final result waits
	a_busy_mid_traversal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_visit |-> in_stall)
		else $error("block idle while a traversal result is not final");

	// clear and traverse always occupy the block after the transfer
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == FUNC_CLEAR || func == FUNC_TRAVERSE) |=> in_stall)
		else $error("block not busy after clear or traverse transfer");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visited_vertex)
			&& $stable(last_visit) && $stable(bad_start))
		else $error("stalled result changed");

endmodule

bind adjacency_matrix_graph_traversal amgt_checker u_amgt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.func           (func),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.visited_vertex (visited_vertex),
	.last_visit     (last_visit),
	.bad_start      (bad_start)
);
